@@ hw/rtl/eclf_pkg.sv @@
// Shared types and constants for the config list framing check.
package eclf_pkg;

   localparam int unsigned DATA_W  = 8;
   localparam int unsigned LEN_W   = 16;
   localparam int unsigned COUNT_W = 17;
   localparam int unsigned ENTRY_W = 14;
   localparam int unsigned ERR_W   = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [ENTRY_W-1:0] ENTRY_MAX = {ENTRY_W{1'b1}};

   // Where the walk stands in the list.
   typedef enum logic [2:0] {
      PH_OUTER_HI = 3'd0,
      PH_OUTER_LO = 3'd1,
      PH_VER_HI   = 3'd2,
      PH_VER_LO   = 3'd3,
      PH_LEN_HI   = 3'd4,
      PH_LEN_LO   = 3'd5,
      PH_BODY     = 3'd6
   } phase_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK           = 3'd0,
      ERR_SHORT        = 3'd1,
      ERR_ZERO_LEN     = 3'd2,
      ERR_LEN_MISMATCH = 3'd3,
      ERR_TRUNC_HDR    = 3'd4,
      ERR_BODY_OVERRUN = 3'd5
   } err_type;

   // One byte handed from the input register to the walker.
   typedef struct packed {
      logic              take;
      logic              last;
      logic [DATA_W-1:0] data_byte;
   } step_type;

   // Verdict for a list, valid on the step that carries the last byte.
   typedef struct packed {
      logic               valid_res;
      err_type            error_code;
      logic [ENTRY_W-1:0] entry_count;
   } verdict_type;

endpackage

@@ hw/rtl/eclf_if.sv @@
// Request and response channel interfaces of the framing check.
interface eclf_req_if;
   import eclf_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;
   logic              last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface eclf_rsp_if;
   import eclf_pkg::*;

   logic               valid;
   logic               ready;
   logic               valid_res;
   logic [ERR_W-1:0]   error_code;
   logic [ENTRY_W-1:0] entry_count;

   modport source (output valid, output valid_res, output error_code, output entry_count,
                   input ready);
   modport sink   (input valid, input valid_res, input error_code, input entry_count,
                   output ready);
endinterface

@@ hw/rtl/eclf_walk.sv @@
// Phase machine, byte counter and verdict logic of the framing check.
module eclf_walk (
   input  logic                  clock,
   input  logic                  reset,
   input  eclf_pkg::step_type    step,
   output eclf_pkg::verdict_type verdict
);
   import eclf_pkg::*;

   phase_type          phase_ff,  phase_in;
   logic [COUNT_W-1:0] count_ff,  count_in;
   logic [LEN_W-1:0]   outer_ff,  outer_in;
   logic [LEN_W-1:0]   body_ff,   body_in;
   logic [DATA_W-1:0]  hold_ff,   hold_in;
   logic [ENTRY_W-1:0] entries_ff, entries_in;
   logic [LEN_W-1:0]   body_dec;
   logic [COUNT_W-1:0] expect_count;
   err_type            err;

   always_comb begin
      phase_in   = phase_ff;
      outer_in   = outer_ff;
      body_in    = body_ff;
      hold_in    = hold_ff;
      entries_in = entries_ff;
      count_in   = (count_ff != COUNT_MAX) ? count_ff + 1'b1 : count_ff;
      body_dec   = (body_ff != '0) ? body_ff - 1'b1 : body_ff;

      unique case (phase_ff)
         PH_OUTER_HI: begin
            hold_in  = step.data_byte;
            phase_in = PH_OUTER_LO;
         end
         PH_OUTER_LO: begin
            outer_in = {hold_ff, step.data_byte};
            phase_in = PH_VER_HI;
         end
         PH_VER_HI: phase_in = PH_VER_LO;
         PH_VER_LO: phase_in = PH_LEN_HI;
         PH_LEN_HI: begin
            hold_in  = step.data_byte;
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            body_in = {hold_ff, step.data_byte};
            if (body_in == '0) begin
               entries_in = (entries_ff != ENTRY_MAX) ? entries_ff + 1'b1 : entries_ff;
               phase_in   = PH_VER_HI;
            end else begin
               phase_in = PH_BODY;
            end
         end
         default: begin
            body_in = body_dec;
            if (body_dec == '0) begin
               entries_in = (entries_ff != ENTRY_MAX) ? entries_ff + 1'b1 : entries_ff;
               phase_in   = PH_VER_HI;
            end
         end
      endcase

      // The outer length plus its own two bytes always fits the counter width.
      expect_count = {1'b0, outer_in} + COUNT_W'(2);

      if (count_in < COUNT_W'(2)) begin
         err = ERR_SHORT;
      end else if (outer_in == '0) begin
         err = ERR_ZERO_LEN;
      end else if (count_in != expect_count) begin
         err = ERR_LEN_MISMATCH;
      end else if (phase_in == PH_VER_HI) begin
         err = ERR_OK;
      end else if (phase_in == PH_VER_LO || phase_in == PH_LEN_HI ||
                   phase_in == PH_LEN_LO) begin
         err = ERR_TRUNC_HDR;
      end else begin
         err = ERR_BODY_OVERRUN;
      end

      verdict.valid_res   = (err == ERR_OK);
      verdict.error_code  = err;
      verdict.entry_count = entries_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step.take && step.last)) begin
         phase_ff   <= PH_OUTER_HI;
         count_ff   <= '0;
         outer_ff   <= '0;
         body_ff    <= '0;
         hold_ff    <= '0;
         entries_ff <= '0;
      end else if (step.take) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         outer_ff   <= outer_in;
         body_ff    <= body_in;
         hold_ff    <= hold_in;
         entries_ff <= entries_in;
      end
   end

endmodule

@@ hw/rtl/ech_config_list_frame_check_core.sv @@
// Top level of the config list framing check: input register, walker, result register.
//
//  Channel  Role    Payload                                 Handshake
//  -------  ------  --------------------------------------  ---------------
//  req      sink    data_byte[7:0], last                    valid / ready
//  rsp      source  valid_res, error_code[2:0],             valid / ready
//                   entry_count[13:0]
//
// One request is taken per clock cycle unless a last request is waiting. A request
// passes through the input register, where the walker updates the list state, and the
// verdict for a request marked last goes on into the result register, which drives rsp.
// Reset clears the valid flags of the input and result registers and all list state.
// A last request waits in the input register only while an earlier verdict is
// still held in the result register; other requests never wait there.
module ech_config_list_frame_check_core (
   input  logic         clock,
   input  logic         reset,
   eclf_req_if.sink     req,
   eclf_rsp_if.source   rsp
);
   import eclf_pkg::*;

   // Input register.
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_last_ff;
   logic [DATA_W-1:0] s1_byte_ff;
   logic              s1_fire;
   logic              req_take;

   // Result register.
   logic               out_valid_ff, out_valid_in;
   logic               out_res_ff;
   logic [ERR_W-1:0]   out_err_ff;
   logic [ENTRY_W-1:0] out_count_ff;

   step_type    step;
   verdict_type verdict;

   // The input register drains whenever its request produces no verdict or the
   // result register is free, or is being emptied in this cycle.
   assign s1_fire     = s1_valid_ff && (!s1_last_ff || !out_valid_ff || rsp.ready);
   assign req.ready   = !s1_valid_ff || s1_fire;
   assign req_take    = req.valid && req.ready;
   assign s1_valid_in = req_take || (s1_valid_ff && !s1_fire);

   always_comb begin
      if (s1_fire && s1_last_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign step.take      = s1_fire;
   assign step.last      = s1_last_ff;
   assign step.data_byte = s1_byte_ff;

   eclf_walk u_walk (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .verdict (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req.data_byte;
         s1_last_ff <= req.last;
      end
      if (s1_fire && s1_last_ff) begin
         out_res_ff   <= verdict.valid_res;
         out_err_ff   <= verdict.error_code;
         out_count_ff <= verdict.entry_count;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.valid_res   = out_res_ff;
   assign rsp.error_code  = out_err_ff;
   assign rsp.entry_count = out_count_ff;

   // A new verdict only ever follows a last request leaving the input register.
   assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s1_fire && s1_last_ff))
      else $error("verdict raised without a last request");

   // The verdict flag agrees with the error code.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_res_ff == (out_err_ff == ERR_OK)))
      else $error("verdict flag disagrees with error code");

   // A request that cannot leave the input register stays there unchanged.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_fire) |=> (s1_valid_ff && $stable(s1_byte_ff) &&
                                     $stable(s1_last_ff)))
      else $error("stalled request lost or changed");

   // A held verdict is not overwritten before it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp.ready) |=> (out_valid_ff && $stable(out_err_ff) &&
                                        $stable(out_count_ff)))
      else $error("held verdict overwritten");

endmodule
